/* sv/an_plus_b_parser_core_macros.svh */
// assertion macros for the an+b parser core
`ifndef AN_PLUS_B_PARSER_CORE_MACROS_SVH
`define AN_PLUS_B_PARSER_CORE_MACROS_SVH

// condition must hold in the same cycle
`define ABP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition must hold in the next cycle
`define ABP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/abp_pkg.sv */
// shared types and character constants for the an+b parser
package abp_pkg;

	localparam int COEF_W = 32;

	// parse phases
	typedef enum logic [2:0] {
		PH_START,
		PH_LEAD,
		PH_AFTN,
		PH_GAP,
		PH_BSIGN,
		PH_BGAP,
		PH_BDIG
	} abp_phase_t;

	typedef enum logic [1:0] {
		SG_NONE,
		SG_PLUS,
		SG_MINUS
	} abp_sign_t;

	// progress through the keywords odd and even
	typedef enum logic [2:0] {
		WM_NONE = 3'd0,
		WM_O    = 3'd1,
		WM_OD   = 3'd2,
		WM_ODD  = 3'd3,
		WM_E    = 3'd4,
		WM_EV   = 3'd5,
		WM_EVE  = 3'd6,
		WM_EVEN = 3'd7
	} abp_word_t;

	typedef struct packed {
		abp_phase_t phase;
		logic       pending_space;
		logic       seen_text;
		abp_sign_t  sign;
		logic       digits_seen;
		abp_word_t  word_match;
		logic       failed;
	} abp_ctl_t;

	localparam abp_ctl_t CTL_RESET = '{
		phase:         PH_START,
		pending_space: 1'b0,
		seen_text:     1'b0,
		sign:          SG_NONE,
		digits_seen:   1'b0,
		word_match:    WM_NONE,
		failed:        1'b0
	};

	typedef struct packed {
		logic                     valid_res;
		logic signed [COEF_W-1:0] coef_a;
		logic signed [COEF_W-1:0] coef_b;
	} abp_result_t;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5a;
	localparam logic [7:0] CH_CASE  = 8'h20;
	localparam logic [7:0] CH_D     = 8'h64;
	localparam logic [7:0] CH_E     = 8'h65;
	localparam logic [7:0] CH_N     = 8'h6e;
	localparam logic [7:0] CH_O     = 8'h6f;
	localparam logic [7:0] CH_V     = 8'h76;

endpackage

/* sv/abp_char_if.sv */
// character channel: one text byte per item
interface abp_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] character;
	logic       last;

	modport source (output valid, output character, output last, input ready);
	modport sink (input valid, input character, input last, output ready);
endinterface

/* sv/abp_result_if.sv */
// result channel: validity and coefficients of one argument
interface abp_result_if;
	logic               valid;
	logic               ready;
	logic               valid_res;
	logic signed [31:0] coef_a;
	logic signed [31:0] coef_b;

	modport source (output valid, output valid_res, output coef_a, output coef_b, input ready);
	modport sink (input valid, input valid_res, input coef_a, input coef_b, output ready);
endinterface

/* sv/abp_step.sv */
// parse state and per-character next-state logic
module abp_step import abp_pkg::*; #(
	parameter int COEF_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  logic [7:0]  character,
	input  logic        last,
	output abp_result_t res,
	output abp_ctl_t    ctl
);

	localparam int AW = COEF_BITS - 1;

	typedef struct packed {
		abp_ctl_t               ctl;
		logic [AW-1:0]          acc;
		logic [COEF_BITS-1:0]   held;
	} abp_pstate_t;

	abp_ctl_t             ctl_q;
	logic [AW-1:0]        acc_q;
	logic [COEF_BITS-1:0] held_q;

	// collapsed space fed before the next visible character
	function automatic abp_pstate_t feed_space(abp_pstate_t s);
		abp_pstate_t n;
		n = s;
		n.ctl.word_match = WM_NONE;
		if (!s.ctl.failed) begin
			if (s.ctl.phase == PH_AFTN) begin
				n.ctl.phase = PH_GAP;
			end else if (s.ctl.phase == PH_BSIGN) begin
				n.ctl.phase = PH_BGAP;
			end else begin
				n.ctl.failed = 1'b1;
			end
		end
		n.ctl.seen_text = 1'b1;
		return n;
	endfunction

	// one visible, case-folded character
	function automatic abp_pstate_t feed_char(abp_pstate_t s, logic [7:0] c);
		abp_pstate_t          n;
		logic                 digit;
		logic                 sgn;
		logic [AW+3:0]        prod;
		logic [AW-1:0]        acc_d;
		abp_sign_t            csign;
		logic [COEF_BITS-1:0] lead_mag;
		n = s;
		digit = (c >= CH_0) && (c <= CH_9);
		sgn = (c == CH_PLUS) || (c == CH_MINUS);
		// times ten as two shifts, saturating at the coefficient maximum
		prod = ({4'b0, s.acc} << 3) + ({4'b0, s.acc} << 1) + {{AW{1'b0}}, c[3:0]};
		acc_d = (prod[AW+3:AW] != 4'b0) ? {AW{1'b1}} : prod[AW-1:0];
		csign = (c == CH_MINUS) ? SG_MINUS : SG_PLUS;
		lead_mag = s.ctl.digits_seen ? {1'b0, s.acc} : COEF_BITS'(1);

		priority if (!s.ctl.seen_text) begin
			n.ctl.word_match = (c == CH_O) ? WM_O : ((c == CH_E) ? WM_E : WM_NONE);
		end else if (s.ctl.word_match == WM_O && c == CH_D) begin
			n.ctl.word_match = WM_OD;
		end else if (s.ctl.word_match == WM_OD && c == CH_D) begin
			n.ctl.word_match = WM_ODD;
		end else if (s.ctl.word_match == WM_E && c == CH_V) begin
			n.ctl.word_match = WM_EV;
		end else if (s.ctl.word_match == WM_EV && c == CH_E) begin
			n.ctl.word_match = WM_EVE;
		end else if (s.ctl.word_match == WM_EVE && c == CH_N) begin
			n.ctl.word_match = WM_EVEN;
		end else begin
			n.ctl.word_match = WM_NONE;
		end

		if (!s.ctl.failed) begin
			unique case (s.ctl.phase)
				PH_START: begin
					if (sgn) begin
						n.ctl.sign = csign;
						n.ctl.phase = PH_LEAD;
					end else if (digit) begin
						n.acc = acc_d;
						n.ctl.digits_seen = 1'b1;
						n.ctl.phase = PH_LEAD;
					end else if (c == CH_N) begin
						n.held = COEF_BITS'(1);
						n.ctl.phase = PH_AFTN;
					end else begin
						n.ctl.failed = 1'b1;
					end
				end
				PH_LEAD: begin
					if (digit) begin
						n.acc = acc_d;
						n.ctl.digits_seen = 1'b1;
					end else if (c == CH_N) begin
						n.held = (s.ctl.sign == SG_MINUS) ? -lead_mag : lead_mag;
						n.ctl.phase = PH_AFTN;
					end else begin
						n.ctl.failed = 1'b1;
					end
				end
				PH_AFTN, PH_GAP: begin
					if (sgn) begin
						n.ctl.sign = csign;
						n.acc = '0;
						n.ctl.digits_seen = 1'b0;
						n.ctl.phase = PH_BSIGN;
					end else begin
						n.ctl.failed = 1'b1;
					end
				end
				PH_BSIGN, PH_BGAP, PH_BDIG: begin
					if (digit) begin
						n.acc = acc_d;
						n.ctl.digits_seen = 1'b1;
						n.ctl.phase = PH_BDIG;
					end else begin
						n.ctl.failed = 1'b1;
					end
				end
				default: begin
					n.ctl.failed = 1'b1;
				end
			endcase
		end
		n.ctl.seen_text = 1'b1;
		return n;
	endfunction

	logic [7:0]           folded;
	logic                 is_ws;
	abp_pstate_t          cur;
	abp_pstate_t          mid;
	abp_pstate_t          nxt;
	logic [COEF_BITS-1:0] b_mag;
	logic [COEF_BITS-1:0] b_val;

	always_comb begin
		folded = ((character >= CH_UA) && (character <= CH_UZ)) ? (character + CH_CASE)
			: character;
		is_ws = (folded == CH_SPACE) || (folded == CH_TAB);
		cur = '{ctl: ctl_q, acc: acc_q, held: held_q};
		mid = (!is_ws && ctl_q.pending_space) ? feed_space(cur) : cur;
		nxt = is_ws ? mid : feed_char(mid, folded);
		if (is_ws) begin
			if (ctl_q.seen_text) begin
				nxt.ctl.pending_space = 1'b1;
			end
		end else begin
			nxt.ctl.pending_space = 1'b0;
		end
	end

	// result from the state after this character
	always_comb begin
		b_mag = {1'b0, nxt.acc};
		b_val = (nxt.ctl.sign == SG_MINUS) ? -b_mag : b_mag;
		res = '0;
		if (nxt.ctl.seen_text) begin
			priority if (nxt.ctl.word_match == WM_ODD) begin
				res.valid_res = 1'b1;
				res.coef_a = COEF_W'(2);
				res.coef_b = COEF_W'(1);
			end else if (nxt.ctl.word_match == WM_EVEN) begin
				res.valid_res = 1'b1;
				res.coef_a = COEF_W'(2);
			end else if (!nxt.ctl.failed) begin
				if (nxt.ctl.phase == PH_LEAD && nxt.ctl.digits_seen) begin
					res.valid_res = 1'b1;
					res.coef_b = COEF_W'(signed'(b_val));
				end else if (nxt.ctl.phase == PH_AFTN || nxt.ctl.phase == PH_GAP) begin
					res.valid_res = 1'b1;
					res.coef_a = COEF_W'(signed'(nxt.held));
				end else if (nxt.ctl.phase == PH_BDIG) begin
					res.valid_res = 1'b1;
					res.coef_a = COEF_W'(signed'(nxt.held));
					res.coef_b = COEF_W'(signed'(b_val));
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= CTL_RESET;
			acc_q <= '0;
			held_q <= '0;
		end else if (adv) begin
			if (last) begin
				ctl_q <= CTL_RESET;
				acc_q <= '0;
				held_q <= '0;
			end else begin
				ctl_q <= nxt.ctl;
				acc_q <= nxt.acc;
				held_q <= nxt.held;
			end
		end
	end

	assign ctl = ctl_q;

endmodule

/* sv/abp_result_reg.sv */
// output register holding one result item for the receiver
module abp_result_reg import abp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  abp_result_t res,
	output logic        free,
	abp_result_if.source out_ch
);

	logic        valid_q;
	abp_result_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= res;
		end
	end

	assign free = !valid_q || out_ch.ready;
	assign out_ch.valid = valid_q;
	assign out_ch.valid_res = data_q.valid_res;
	assign out_ch.coef_a = data_q.coef_a;
	assign out_ch.coef_b = data_q.coef_b;

endmodule

/* sv/an_plus_b_parser_core.sv */
// top level of the an+b argument parser
// use: send the argument text on in_ch, one byte per item, with last set on
//   the final byte; one result item per argument comes out on out_ch
// in_ch carries character and last, out_ch carries valid_res, coef_a, coef_b
// case is folded, whitespace runs collapse to one space, ends are trimmed
// path: the last item is accepted into the input register, then passes the
//   next-state logic into the output register once the result slot is free,
//   and the result is offered on out_ch from the output register
// throughput: one item per cycle unless a last byte waits on a held result,
//   limited by the update of the parse state, which every byte reads and writes
// reset: clears the input stage, the parse state and the output register;
//   the block accepts items as soon as reset is released
// stall: a held result blocks only a last item behind it; other bytes keep
//   flowing into the parse state, and in_ch.ready drops once the input
//   register holds a last byte that cannot yet be handed on
// COEF_BITS sets the accumulator width and the digit saturation point;
//   the coefficients are sign-extended to 32 bits (truncated if COEF_BITS > 32)
module an_plus_b_parser_core import abp_pkg::*; #(
	parameter int COEF_BITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	abp_char_if.sink   in_ch,
	abp_result_if.source out_ch
);

	// input register
	logic        valid_s1;
	logic [7:0]  char_s1;
	logic        last_s1;

	logic        adv;
	logic        free;
	abp_result_t res;
	abp_ctl_t    ctl;

	// an item leaves the input stage unless it is last and the result slot is full
	assign adv = valid_s1 && (!last_s1 || free);
	assign in_ch.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.valid && in_ch.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			char_s1 <= in_ch.character;
			last_s1 <= in_ch.last;
		end
	end

	// parse state and next-state logic
	abp_step #(
		.COEF_BITS(COEF_BITS)
	) u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.character (char_s1),
		.last      (last_s1),
		.res       (res),
		.ctl       (ctl)
	);

	// result register towards the receiver
	abp_result_reg u_result (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (adv && last_s1),
		.res    (res),
		.free   (free),
		.out_ch (out_ch)
	);

	`include "an_plus_b_parser_core_macros.svh"

	// a finished argument is offered in the next cycle
	`ABP_ASSERT_NEXT(a_result_loaded, adv && last_s1, out_ch.valid, "result not offered")
	// the parser is re-armed after each argument
	`ABP_ASSERT_NEXT(a_rearmed, adv && last_s1, ctl == CTL_RESET, "parse state not cleared")
	// with room at the output the block never stalls its sender
	`ABP_ASSERT_NOW(a_no_stall, !out_ch.valid || out_ch.ready, in_ch.ready, "needless stall")
	// a syntax error carries zero coefficients
	`ABP_ASSERT_NOW(a_err_zero, out_ch.valid && !out_ch.valid_res,
		(out_ch.coef_a == 0) && (out_ch.coef_b == 0), "error with coefficients")

endmodule
